@@ hdl/taac_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-axis angle constrainer package
// Shared constants, register indexes, status codes and pipeline records.
// ----------------------------------------------------------------------------
package taac_pkg;

  localparam int FRACTION_BITS_DEF  = 6;
  localparam int MAX_HALF_TURNS_DEF = 8;

  localparam int ANGLE_W      = 17;
  localparam int LIMIT_W      = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int IN_TDATA_W   = 56;
  localparam int OUT_TDATA_W  = 40;

  localparam logic signed [LIMIT_W-1:0] FIRST_MIN_RST  = -16'sd5760;
  localparam logic signed [LIMIT_W-1:0] FIRST_MAX_RST  = 16'sd5760;
  localparam logic signed [LIMIT_W-1:0] SECOND_MIN_RST = -16'sd5760;
  localparam logic signed [LIMIT_W-1:0] SECOND_MAX_RST = 16'sd5760;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIRST_MIN  = 2'd0,
    REG_FIRST_MAX  = 2'd1,
    REG_SECOND_MIN = 2'd2,
    REG_SECOND_MAX = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_UNCHANGED = 2'd0,
    STATUS_VALID     = 2'd1,
    STATUS_RESTORED  = 2'd2,
    STATUS_NARROW    = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [LIMIT_W-1:0] first_min;
    logic signed [LIMIT_W-1:0] first_max;
    logic signed [LIMIT_W-1:0] second_min;
    logic signed [LIMIT_W-1:0] second_max;
  } limits_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] req1;
    logic signed [ANGLE_W-1:0] req2;
    logic signed [ANGLE_W-1:0] start;
    logic                      narrow;
  } item_t;

endpackage

@@ hdl/taac_turn_stage.sv @@
// ----------------------------------------------------------------------------
// Half-turn stage
// One conditional half turn of the first axis, with the second axis negated.
// ----------------------------------------------------------------------------
module taac_turn_stage #(
  parameter int AW            = 29,
  parameter int FRACTION_BITS = taac_pkg::FRACTION_BITS_DEF,
  parameter bit TURN_UP       = 1'b1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  taac_pkg::limits_t      lim,
  input  logic                   in_valid,
  input  taac_pkg::item_t        in_item,
  input  logic signed [AW-1:0]   in_a1,
  input  logic signed [AW-1:0]   in_a2,
  input  logic                   in_changed,
  output logic                   out_valid,
  output taac_pkg::item_t        out_item,
  output logic signed [AW-1:0]   out_a1,
  output logic signed [AW-1:0]   out_a2,
  output logic                   out_changed
);
  import taac_pkg::*;

  localparam logic signed [AW-1:0] HALF_TURN = AW'(180 * (2 ** FRACTION_BITS));

  logic turn;

  always_comb begin
    if (TURN_UP) begin
      turn = in_a1 < AW'(lim.first_min);
    end else begin
      turn = in_a1 > AW'(lim.first_max);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item    <= in_item;
      out_changed <= in_changed | turn;
      if (turn) begin
        out_a1 <= TURN_UP ? in_a1 + HALF_TURN : in_a1 - HALF_TURN;
        out_a2 <= -in_a2;
      end else begin
        out_a1 <= in_a1;
        out_a2 <= in_a2;
      end
    end
  end

endmodule

@@ hdl/two_axis_angle_constrainer.sv @@
// ----------------------------------------------------------------------------
// Two-axis angle constrainer
// Brings a requested mirror pose into the configured axis limits by half
// turns, tries one more flip toward the start angle and reports a status.
// ----------------------------------------------------------------------------
// The pipeline has one stage per possible half turn, two flip stages and
// the output register. Throughput is one beat per cycle; the whole pipeline
// holds while a result waits at the output. Reset empties the pipeline and
// loads the default limits of plus and minus 90 degrees on both axes.
module two_axis_angle_constrainer #(
  parameter int FRACTION_BITS  = taac_pkg::FRACTION_BITS_DEF,
  parameter int MAX_HALF_TURNS = taac_pkg::MAX_HALF_TURNS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // first_axis_in, second_axis_in, start_first_axis, unused bits
  input  logic [taac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // first_axis_out, second_axis_out, status, zero fill
  output logic [taac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [taac_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [taac_pkg::LIMIT_W-1:0]        cfg_data
);
  import taac_pkg::*;

  localparam int AW = 19 + FRACTION_BITS + $clog2(MAX_HALF_TURNS + 1);
  localparam int NS = 2 * MAX_HALF_TURNS;
  localparam logic signed [AW-1:0] HALF_TURN    = AW'(180 * (2 ** FRACTION_BITS));
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(90 * (2 ** FRACTION_BITS));

  limits_t lim;
  logic    en;

  logic                  v   [NS+1];
  item_t                 it  [NS+1];
  logic signed [AW-1:0]  a1  [NS+1];
  logic signed [AW-1:0]  a2  [NS+1];
  logic                  chg [NS+1];

  logic                  f1_valid;
  item_t                 f1_item;
  logic signed [AW-1:0]  f1_a1;
  logic signed [AW-1:0]  f1_a2;
  logic signed [AW-1:0]  f1_cand;
  logic                  f1_changed;
  logic                  f1_try;

  logic                  f2_valid;
  item_t                 f2_item;
  logic signed [AW-1:0]  f2_a1;
  logic signed [AW-1:0]  f2_a2;
  logic                  f2_changed;

  logic signed [AW-1:0]  moved;
  logic                  move_dn;
  logic                  move_up;
  logic                  cand_ok;
  logic                  pose_ok;
  status_t               status;

  function automatic logic pose_valid(input logic signed [AW-1:0] p1,
                                      input logic signed [AW-1:0] p2,
                                      input limits_t l);
    pose_valid = p1 >= AW'(l.first_min) && p1 <= AW'(l.first_max) &&
                 p2 >= AW'(l.second_min) && p2 <= AW'(l.second_max);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.first_min  <= FIRST_MIN_RST;
      lim.first_max  <= FIRST_MAX_RST;
      lim.second_min <= SECOND_MIN_RST;
      lim.second_max <= SECOND_MAX_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_FIRST_MIN:  lim.first_min  <= cfg_data;
        REG_FIRST_MAX:  lim.first_max  <= cfg_data;
        REG_SECOND_MIN: lim.second_min <= cfg_data;
        REG_SECOND_MAX: lim.second_max <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    v[0]          = s_axis_tvalid;
    it[0].req1    = s_axis_tdata[ANGLE_W-1:0];
    it[0].req2    = s_axis_tdata[2*ANGLE_W-1:ANGLE_W];
    it[0].start   = s_axis_tdata[3*ANGLE_W-1:2*ANGLE_W];
    it[0].narrow  = (AW'(lim.first_max) - AW'(lim.first_min)) < HALF_TURN;
    a1[0]         = AW'(it[0].req1);
    a2[0]         = AW'(it[0].req2);
    chg[0]        = 1'b0;
  end

  for (genvar k = 0; k < NS; k++) begin : g_turn
    taac_turn_stage #(
      .AW            (AW),
      .FRACTION_BITS (FRACTION_BITS),
      .TURN_UP       (k < MAX_HALF_TURNS)
    ) u_stage (
      .clk         (clk),
      .rst         (rst),
      .en          (en),
      .lim         (lim),
      .in_valid    (v[k]),
      .in_item     (it[k]),
      .in_a1       (a1[k]),
      .in_a2       (a2[k]),
      .in_changed  (chg[k]),
      .out_valid   (v[k+1]),
      .out_item    (it[k+1]),
      .out_a1      (a1[k+1]),
      .out_a2      (a2[k+1]),
      .out_changed (chg[k+1])
    );
  end

  always_comb begin
    moved   = a1[NS] - AW'(it[NS].start);
    move_dn = moved > QUARTER_TURN;
    move_up = moved < -QUARTER_TURN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_item    <= it[NS];
      f1_a1      <= a1[NS];
      f1_a2      <= a2[NS];
      f1_changed <= chg[NS];
      f1_try     <= move_dn | move_up;
      f1_cand    <= move_dn ? a1[NS] - HALF_TURN : a1[NS] + HALF_TURN;
    end
  end

  assign cand_ok = pose_valid(f1_cand, -f1_a2, lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_item <= f1_item;
      if (f1_try && cand_ok) begin
        f2_a1      <= f1_cand;
        f2_a2      <= -f1_a2;
        f2_changed <= 1'b1;
      end else begin
        f2_a1      <= f1_a1;
        f2_a2      <= f1_a2;
        f2_changed <= f1_changed;
      end
    end
  end

  always_comb begin
    pose_ok = pose_valid(f2_a1, f2_a2, lim);
    if (f2_item.narrow) begin
      status = STATUS_NARROW;
    end else if (!f2_changed) begin
      status = STATUS_UNCHANGED;
    end else if (pose_ok) begin
      status = STATUS_VALID;
    end else begin
      status = STATUS_RESTORED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (status == STATUS_VALID) begin
        m_axis_tdata[ANGLE_W-1:0]         <= f2_a1[ANGLE_W-1:0];
        m_axis_tdata[2*ANGLE_W-1:ANGLE_W] <= f2_a2[ANGLE_W-1:0];
      end else begin
        m_axis_tdata[ANGLE_W-1:0]         <= f2_item.req1;
        m_axis_tdata[2*ANGLE_W-1:ANGLE_W] <= f2_item.req2;
      end
      m_axis_tdata[2*ANGLE_W+1:2*ANGLE_W]       <= status;
      m_axis_tdata[OUT_TDATA_W-1:2*ANGLE_W+2]   <= '0;
    end
  end

endmodule
